>>> rtl/core/cfee_pkg.sv
// Shared types, constants and escape functions for the copy-field escape encoder.
`default_nettype none

package cfee_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_T         = 8'h74;
  localparam logic [7:0] CHAR_N         = 8'h6E;
  localparam logic [7:0] CHAR_R         = 8'h72;
  localparam logic [7:0] CHAR_TAB       = 8'h09;
  localparam logic [7:0] CHAR_LF        = 8'h0A;
  localparam logic [7:0] CHAR_CR        = 8'h0D;
  localparam logic [7:0] PRINT_LOW      = 8'd32;
  localparam logic [7:0] PRINT_HIGH     = 8'd126;

  localparam logic MODE_TEXT   = 1'b0;
  localparam logic MODE_BINARY = 1'b1;

  typedef enum logic [1:0] {
    KIND_PASS  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_QUAD  = 2'd2,
    KIND_OCTAL = 2'd3
  } kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       datum_end_in;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       datum_end_out;
  } out_req_t;

  // For a pair escape, data holds the letter that follows the backslash.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       datum_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic cmd_t classify(input logic mode, input in_req_t req);
    cmd_t c;
    c.kind      = KIND_PASS;
    c.data      = req.in_byte;
    c.datum_end = req.datum_end_in;
    if (mode == MODE_BINARY) begin
      if (req.in_byte == CHAR_BACKSLASH) begin
        c.kind = KIND_QUAD;
      end else if (req.in_byte < PRINT_LOW || req.in_byte > PRINT_HIGH) begin
        c.kind = KIND_OCTAL;
      end
    end else begin
      case (req.in_byte)
        CHAR_TAB: begin
          c.kind = KIND_PAIR;
          c.data = CHAR_T;
        end
        CHAR_LF: begin
          c.kind = KIND_PAIR;
          c.data = CHAR_N;
        end
        CHAR_CR: begin
          c.kind = KIND_PAIR;
          c.data = CHAR_R;
        end
        CHAR_BACKSLASH: begin
          c.kind = KIND_PAIR;
          c.data = CHAR_BACKSLASH;
        end
        default: begin
          c.kind = KIND_PASS;
        end
      endcase
    end
    return c;
  endfunction

  function automatic logic [2:0] run_length(input kind_t kind);
    logic [2:0] len;
    case (kind)
      KIND_PASS:  len = 3'd1;
      KIND_PAIR:  len = 3'd2;
      KIND_QUAD:  len = 3'd4;
      KIND_OCTAL: len = 3'd5;
      default:    len = 3'd1;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] run_byte(input cmd_t c, input logic [2:0] pos);
    logic [7:0] b;
    case (c.kind)
      KIND_PASS:  b = c.data;
      KIND_PAIR:  b = (pos == 3'd0) ? CHAR_BACKSLASH : c.data;
      KIND_QUAD:  b = CHAR_BACKSLASH;
      KIND_OCTAL: begin
        case (pos)
          3'd2:    b = CHAR_ZERO | {6'd0, c.data[7:6]};
          3'd3:    b = CHAR_ZERO | {5'd0, c.data[5:3]};
          3'd4:    b = CHAR_ZERO | {5'd0, c.data[2:0]};
          default: b = CHAR_BACKSLASH;
        endcase
      end
      default:    b = c.data;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/copy_field_escape_encoder.sv
// Top level of the copy-field escape encoder: mode register, front end, queue and back end.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  in_req  (in_byte, datum_end_in)
//   out      output     out_valid/out_stall  out_req (out_byte, run_last, datum_end_out)
//   cfg      input      cfg_write            cfg_data (escape_mode)
//
// The back end emits one output byte per cycle while out_stall is low, and an input
// request expands into one to five output bytes: one for a plain byte, two for a
// text escape, four for a binary backslash and five for an octal escape.
// A new input request is taken whenever the command queue has room; the queue
// holds QUEUE_DEPTH commands. Reset is synchronous and clears the mode, the queue
// and the output valid; the first request can be taken in the cycle after reset.
`default_nettype none

module copy_field_escape_encoder #(
  parameter int QUEUE_DEPTH = cfee_pkg::QUEUE_DEPTH
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire                 cfg_data,
  input  wire                 in_valid,
  output logic                in_stall,
  input  cfee_pkg::in_req_t   in_req,
  output logic                out_valid,
  input  wire                 out_stall,
  output cfee_pkg::out_req_t  out_req
);

  logic                escape_mode;
  logic                push;
  logic                pop;
  cfee_pkg::cmd_t      push_cmd;
  cfee_pkg::cmd_t      head_cmd;
  cfee_pkg::q_status_t q_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_mode <= cfee_pkg::MODE_TEXT;
    end else if (cfg_write) begin
      escape_mode <= cfg_data;
    end
  end

  cfee_front u_front (
    .rst         (rst),
    .escape_mode (escape_mode),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req      (in_req),
    .q_status    (q_status),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  cfee_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_status (q_status)
  );

  cfee_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head_cmd  (head_cmd),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty at once");

  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !q_status.empty)
    else $error("accepted request did not reach the queue");

  a_end_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_req.datum_end_out) |-> out_req.run_last)
    else $error("datum end flagged on a byte that is not the last of its run");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("back end popped an empty queue");

endmodule

`default_nettype wire

>>> rtl/core/cfee_front.sv
// Front end: accepts input requests and classifies each byte into an escape command.
`default_nettype none

module cfee_front (
  input  wire                  rst,
  input  wire                  escape_mode,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  cfee_pkg::in_req_t    in_req,
  input  cfee_pkg::q_status_t  q_status,
  output logic                 push,
  output cfee_pkg::cmd_t       push_cmd
);

  assign in_stall = rst || q_status.full;
  assign push     = in_valid && !in_stall;
  assign push_cmd = cfee_pkg::classify(escape_mode, in_req);

endmodule

`default_nettype wire

>>> rtl/core/cfee_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module cfee_queue #(
  parameter int DEPTH = cfee_pkg::QUEUE_DEPTH
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  cfee_pkg::cmd_t       push_cmd,
  input  wire                  pop,
  output cfee_pkg::cmd_t       head_cmd,
  output cfee_pkg::q_status_t  q_status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cfee_pkg::cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign do_push = push && !q_status.full;
  assign do_pop  = pop && !q_status.empty;
  assign head_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/cfee_back.sv
// Back end: expands queued commands into registered output bytes, one per unstalled cycle.
`default_nettype none

module cfee_back (
  input  wire                  clk,
  input  wire                  rst,
  input  cfee_pkg::cmd_t       head_cmd,
  input  cfee_pkg::q_status_t  q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output cfee_pkg::out_req_t   out_req
);

  logic [2:0] pos;
  logic [2:0] pos_next;
  logic       load;
  logic       at_last;

  assign load    = (!out_valid || !out_stall) && !q_status.empty;
  assign at_last = (pos == cfee_pkg::run_length(head_cmd.kind) - 3'd1);
  assign pop     = load && at_last;

  always_comb begin
    pos_next = pos;
    if (load) begin
      pos_next = at_last ? 3'd0 : pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else begin
      pos <= pos_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_req.out_byte      <= cfee_pkg::run_byte(head_cmd, pos);
      out_req.run_last      <= at_last;
      out_req.datum_end_out <= at_last && head_cmd.datum_end;
    end
  end

endmodule

`default_nettype wire
